/* hdl/triangle_perimeter_check_macros.svh */
// Assertion macros shared by the triangle perimeter check RTL.
`ifndef TRIANGLE_PERIMETER_CHECK_MACROS_SVH
`define TRIANGLE_PERIMETER_CHECK_MACROS_SVH
`ifndef SYNTH
`define TPC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TPC_ASSERT(label, clk, rst_n, prop)
`define TPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tpc_pkg.sv */
// Shared widths and limits of the triangle perimeter check.
package tpc_pkg;
  localparam int unsigned CoordFieldW = 16;
  localparam int unsigned PerimW = 27;
  localparam logic [PerimW-1:0] PerimMax = '1;
endpackage

/* hdl/triangle_perimeter_check.sv */
// Triangle perimeter check.
// Throughput is one transaction per cycle while the output is not stalled; the square root
// pipeline resolves one root bit per stage for all three sides in parallel.
// A stall at the output holds every stage in place.
// Reset clears all stage valid bits asynchronously; data registers are not reset.
module triangle_perimeter_check #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [tpc_pkg::CoordFieldW-1:0] first_x_i,
  input  logic signed [tpc_pkg::CoordFieldW-1:0] first_y_i,
  input  logic signed [tpc_pkg::CoordFieldW-1:0] second_x_i,
  input  logic signed [tpc_pkg::CoordFieldW-1:0] second_y_i,
  input  logic signed [tpc_pkg::CoordFieldW-1:0] third_x_i,
  input  logic signed [tpc_pkg::CoordFieldW-1:0] third_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_triangle_o,
  output logic [tpc_pkg::PerimW-1:0]    perimeter_o,
  output logic                          right_angled_o
);
  import tpc_pkg::*;
`include "triangle_perimeter_check_macros.svh"

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned EW = (CW > CoordFieldW) ? CW : CoordFieldW;
  localparam int unsigned SQW = 2 * CW + 2;
  localparam int unsigned NW = SQW + 2 * FRAC_BITS;
  localparam int unsigned RB = NW / 2;
  localparam int unsigned SW = (RB + 2 > PerimW + 1) ? RB + 2 : PerimW + 1;
  localparam int unsigned DEPTH = RB + 4;

  logic [DEPTH-1:0] v_q;
  logic en;

  assign en = !v_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[DEPTH-2:0], in_valid_i};
    end
  end

  // Stage 1: coordinate extraction and edge differences.
  logic [EW-1:0] raw [6];
  logic signed [CW-1:0] crd [6];
  logic signed [CW:0] e_d [6];
  logic signed [CW:0] e_q [6];

  always_comb begin
    raw[0] = EW'($unsigned(first_x_i));
    raw[1] = EW'($unsigned(first_y_i));
    raw[2] = EW'($unsigned(second_x_i));
    raw[3] = EW'($unsigned(second_y_i));
    raw[4] = EW'($unsigned(third_x_i));
    raw[5] = EW'($unsigned(third_y_i));
    for (int i = 0; i < 6; i++) begin
      crd[i] = $signed(raw[i][CW-1:0]);
    end
    e_d[0] = (CW+1)'(crd[2]) - (CW+1)'(crd[0]);
    e_d[1] = (CW+1)'(crd[3]) - (CW+1)'(crd[1]);
    e_d[2] = (CW+1)'(crd[4]) - (CW+1)'(crd[2]);
    e_d[3] = (CW+1)'(crd[5]) - (CW+1)'(crd[3]);
    e_d[4] = (CW+1)'(crd[4]) - (CW+1)'(crd[0]);
    e_d[5] = (CW+1)'(crd[5]) - (CW+1)'(crd[1]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q <= e_d;
    end
  end

  // Stage 2: squares and cross products.
  logic signed [2*CW+1:0] sqr_q [6];
  logic signed [2*CW+1:0] p1_q, p2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        sqr_q[i] <= (2*CW+2)'(e_q[i]) * (2*CW+2)'(e_q[i]);
      end
      p1_q <= (2*CW+2)'(e_q[0]) * (2*CW+2)'(e_q[5]);
      p2_q <= (2*CW+2)'(e_q[1]) * (2*CW+2)'(e_q[4]);
    end
  end

  // Stage 3: squared side lengths and collinearity.
  logic [SQW-1:0] side_q [3];
  logic tri_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 3; s++) begin
        side_q[s] <= $unsigned(sqr_q[2*s]) + $unsigned(sqr_q[2*s+1]);
      end
      tri_q <= (p1_q != p2_q);
    end
  end

  // Square root stages, one result bit per stage.
  logic [NW-1:0] rem_q  [RB+1][3];
  logic [NW-1:0] root_q [RB+1][3];
  logic          trs_q  [RB+1];
  logic          rts_q  [RB+1];

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      rem_q[0][s]  = NW'(side_q[s]) << (2 * FRAC_BITS);
      root_q[0][s] = '0;
    end
    trs_q[0] = tri_q;
    rts_q[0] = ((side_q[0] + side_q[1]) == side_q[2])
            || ((side_q[0] + side_q[2]) == side_q[1])
            || ((side_q[1] + side_q[2]) == side_q[0]);
  end

  for (genvar j = 1; j <= RB; j++) begin : g_root
    localparam logic [NW-1:0] Bit = NW'(1) << (2 * (RB - j));
    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int s = 0; s < 3; s++) begin
          if (rem_q[j-1][s] >= root_q[j-1][s] + Bit) begin
            rem_q[j][s]  <= rem_q[j-1][s] - (root_q[j-1][s] + Bit);
            root_q[j][s] <= (root_q[j-1][s] >> 1) + Bit;
          end else begin
            rem_q[j][s]  <= rem_q[j-1][s];
            root_q[j][s] <= root_q[j-1][s] >> 1;
          end
        end
        trs_q[j] <= trs_q[j-1];
        rts_q[j] <= rts_q[j-1];
      end
    end
  end

  // Final stage: perimeter sum, saturation and degenerate masking.
  logic [SW-1:0] tot;
  logic [PerimW-1:0] perim_q;
  logic tri_out_q, right_q;

  assign tot = SW'(root_q[RB][0][RB-1:0]) + SW'(root_q[RB][1][RB-1:0])
             + SW'(root_q[RB][2][RB-1:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tri_out_q <= trs_q[RB];
      right_q   <= trs_q[RB] && rts_q[RB];
      if (!trs_q[RB]) begin
        perim_q <= '0;
      end else if (tot > SW'(PerimMax)) begin
        perim_q <= PerimMax;
      end else begin
        perim_q <= tot[PerimW-1:0];
      end
    end
  end

  assign out_valid_o    = v_q[DEPTH-1];
  assign is_triangle_o  = tri_out_q;
  assign perimeter_o    = perim_q;
  assign right_angled_o = right_q;

  `TPC_ASSERT(a_degen_zero, clk_i, rst_ni, (out_valid_o && !is_triangle_o) |-> (perimeter_o == '0 && !right_angled_o))
  `TPC_ASSERT(a_right_tri, clk_i, rst_ni, (out_valid_o && right_angled_o) |-> is_triangle_o)
  `TPC_ASSERT(a_stall_block, clk_i, rst_ni, (out_valid_o && !out_ready_i) |-> !in_ready_o)
  `TPC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(v_q))
endmodule
